// ----- rtl/core/isoej_pkg.sv -----
// shared types and constants for the iso-2022-jp to euc-jp decoder
`timescale 1ns / 1ps
`default_nettype none
package isoej_pkg;

    localparam logic [7:0] ESC_BYTE  = 8'h1B;
    localparam logic [7:0] HIGH_BIT  = 8'h80;
    localparam logic [7:0] SS2_BYTE  = 8'h8E;
    localparam logic [7:0] SS3_BYTE  = 8'h8F;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_J      = 8'h4A;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_Q      = 8'h51;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PAREN  = 8'h28;

    localparam logic [1:0] MODE_ASCII = 2'd0;
    localparam logic [1:0] MODE_KANJI = 2'd1;
    localparam logic [1:0] MODE_KANA  = 2'd2;
    localparam logic [1:0] MODE_SUPP  = 2'd3;

    localparam logic [2:0] PH_NONE       = 3'd0;
    localparam logic [2:0] PH_ESC        = 3'd1;
    localparam logic [2:0] PH_ESC_PAREN  = 3'd2;
    localparam logic [2:0] PH_ESC_DOLLAR = 3'd3;
    localparam logic [2:0] PH_ESC_DP     = 3'd4;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       error;
        logic       last;
    } t_result;

    // results caused by one request, in order
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_step;

endpackage
`default_nettype wire

// ----- rtl/core/isoej_ifs.sv -----
// valid/ready channel interfaces for the input and result streams
`timescale 1ns / 1ps
`default_nettype none
interface isoej_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface isoej_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       error;
    logic       last;
    modport source (output valid, output out_byte, output error, output last, input ready);
    modport sink (input valid, input out_byte, input error, input last, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/iso2022jp_to_eucjp_decoder.sv -----
// top level of the iso-2022-jp to euc-jp stream decoder
`timescale 1ns / 1ps
`default_nettype none
// Converts an ISO-2022-JP byte stream into EUC-JP, one input byte per request
// on i_in and one result per request on o_out. A byte is taken into an input
// register, decoded there in a single pass against the escape/charset state,
// and its zero, one or two results are written into a four-entry result queue
// that drives o_out directly. A new byte can be accepted every cycle while the
// queue has room for a two-result byte. The sustained rate is set by the result
// port, which moves one result per cycle while o_out.ready is high: ASCII,
// JIS X 0208 and JIS X 0212 trail bytes give one result each, kana bytes and
// JIS X 0212 lead bytes give two, escape bytes give no result. An unknown
// escape gives one result with error set and out_byte zero, after which every
// byte is taken and dropped until reset. No flush is done at end of stream; a
// half-received character simply stays pending.
module iso2022jp_to_eucjp_decoder
    import isoej_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    isoej_in_if.sink     i_in,
    isoej_out_if.source  o_out
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       room;
    logic       advance;
    t_step      step;

    // decode the held byte only when the queue can take both possible results
    assign advance  = r_in_valid && room;
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.in_byte;
        end
    end

    // escape parser and charset state, results for the held byte
    isoej_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (advance),
        .i_byte  (r_in_byte),
        .o_step  (step)
    );

    // result queue, also the output register of the block
    isoej_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .o_room  (room),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

// ----- rtl/core/isoej_decode.sv -----
// escape parser, charset state and per-byte result generation
`timescale 1ns / 1ps
`default_nettype none
module isoej_decode
    import isoej_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    output t_step           o_step
);

    logic [1:0] r_mode, n_mode;
    logic [2:0] r_phase, n_phase;
    logic       r_sbd, n_sbd;
    logic       r_halted, n_halted;
    logic       fail;
    logic [7:0] hi_byte;

    assign hi_byte = i_byte | HIGH_BIT;

    always_comb begin
        n_mode   = r_mode;
        n_phase  = r_phase;
        n_sbd    = r_sbd;
        n_halted = r_halted;
        fail     = 1'b0;
        o_step   = '0;
        if (i_valid && !r_halted) begin
            if (r_sbd) begin
                n_sbd = 1'b0;
                o_step.cnt = 2'd1;
                o_step.r0  = '{out_byte: hi_byte, error: 1'b0, last: 1'b1};
            end else begin
                case (r_phase)
                    PH_NONE: begin
                        if (i_byte == ESC_BYTE) begin
                            n_phase = PH_ESC;
                        end else begin
                            case (r_mode)
                                MODE_ASCII: begin
                                    o_step.cnt = 2'd1;
                                    o_step.r0  = '{out_byte: i_byte, error: 1'b0, last: 1'b1};
                                end
                                MODE_KANJI: begin
                                    n_sbd = 1'b1;
                                    o_step.cnt = 2'd1;
                                    o_step.r0  = '{out_byte: hi_byte, error: 1'b0, last: 1'b1};
                                end
                                MODE_KANA: begin
                                    o_step.cnt = 2'd2;
                                    o_step.r0  = '{out_byte: SS2_BYTE, error: 1'b0, last: 1'b0};
                                    o_step.r1  = '{out_byte: hi_byte, error: 1'b0, last: 1'b1};
                                end
                                default: begin
                                    n_sbd = 1'b1;
                                    o_step.cnt = 2'd2;
                                    o_step.r0  = '{out_byte: SS3_BYTE, error: 1'b0, last: 1'b0};
                                    o_step.r1  = '{out_byte: hi_byte, error: 1'b0, last: 1'b1};
                                end
                            endcase
                        end
                    end
                    PH_ESC: begin
                        if (i_byte == CH_PAREN) begin
                            n_phase = PH_ESC_PAREN;
                        end else if (i_byte == CH_DOLLAR) begin
                            n_phase = PH_ESC_DOLLAR;
                        end else begin
                            fail = 1'b1;
                        end
                    end
                    PH_ESC_PAREN: begin
                        n_phase = PH_NONE;
                        if (i_byte == CH_B || i_byte == CH_J) begin
                            n_mode = MODE_ASCII;
                        end else if (i_byte == CH_I) begin
                            n_mode = MODE_KANA;
                        end else begin
                            fail = 1'b1;
                        end
                    end
                    PH_ESC_DOLLAR: begin
                        if (i_byte == CH_PAREN) begin
                            n_phase = PH_ESC_DP;
                        end else begin
                            n_phase = PH_NONE;
                            if (i_byte == CH_AT || i_byte == CH_B) begin
                                n_mode = MODE_KANJI;
                            end else begin
                                fail = 1'b1;
                            end
                        end
                    end
                    PH_ESC_DP: begin
                        n_phase = PH_NONE;
                        if (i_byte == CH_D) begin
                            n_mode = MODE_SUPP;
                        end else if (i_byte == CH_Q) begin
                            n_mode = MODE_KANJI;
                        end else begin
                            fail = 1'b1;
                        end
                    end
                    default: begin
                        fail = 1'b1;
                    end
                endcase
                if (fail) begin
                    n_halted   = 1'b1;
                    n_phase    = PH_NONE;
                    n_sbd      = 1'b0;
                    o_step.cnt = 2'd1;
                    o_step.r0  = '{out_byte: 8'h00, error: 1'b1, last: 1'b1};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_ASCII;
            r_phase  <= PH_NONE;
            r_sbd    <= 1'b0;
            r_halted <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_phase  <= n_phase;
            r_sbd    <= n_sbd;
            r_halted <= n_halted;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/isoej_out_fifo.sv -----
// small result queue: takes up to two results a cycle, hands out one when the sink is ready
`timescale 1ns / 1ps
`default_nettype none
module isoej_out_fifo
    import isoej_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_step i_step,
    output logic       o_room,
    isoej_out_if.source o_out
);

    t_result        r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QAW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QAW:0]   r_count, n_count;
    logic           pop;
    logic [QAW-1:0] wr_ptr1;

    assign pop     = o_out.valid && o_out.ready;
    // room for a full two-result request
    assign o_room  = r_count <= (QAW+1)'(QDEPTH - 2);
    assign wr_ptr1 = r_wr_ptr + QAW'(1);

    assign o_out.valid    = r_count != '0;
    assign o_out.out_byte = r_mem[r_rd_ptr].out_byte;
    assign o_out.error    = r_mem[r_rd_ptr].error;
    assign o_out.last     = r_mem[r_rd_ptr].last;

    always_comb begin
        n_wr_ptr = r_wr_ptr + QAW'(i_step.cnt);
        n_rd_ptr = r_rd_ptr + QAW'(pop);
        n_count  = r_count + (QAW+1)'(i_step.cnt) - (QAW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_step.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_step.r0;
        end
        if (i_step.cnt == 2'd2) begin
            r_mem[wr_ptr1] <= i_step.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/isoej_checker.sv -----
// port-level checks on the result stream, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module isoej_checker
    import isoej_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       i_ready,
    input wire logic [7:0] i_out_byte,
    input wire logic       i_error,
    input wire logic       i_last
);

    // an error result stands alone and carries a zero byte
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_error |-> i_last && i_out_byte == 8'h00)
        else $error("error result not last or byte not zero");

    // nothing follows an error result
    a_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && i_error |=> !i_valid)
        else $error("result after error");

    // only a single-shift prefix (SS2 or SS3) is offered as a non-last result
    a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_last |-> i_out_byte == SS2_BYTE || i_out_byte == SS3_BYTE)
        else $error("non-last result is not a prefix byte");

    // a taken prefix is followed by a last, error-free byte with the high bit set
    a_after_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && !i_last ##1 i_valid |-> i_out_byte[7] && i_last && !i_error)
        else $error("prefix not followed by high byte");

endmodule

bind iso2022jp_to_eucjp_decoder isoej_checker u_isoej_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (o_out.valid),
    .i_ready    (o_out.ready),
    .i_out_byte (o_out.out_byte),
    .i_error    (o_out.error),
    .i_last     (o_out.last)
);
`default_nettype wire
